### sv/ryd_pkg.sv
`timescale 1ns / 1ps
// shared constants, coefficients and stage type for the rgb to yuv 4:2:0 block
package ryd_pkg;

    localparam int MAX_WIDTH = 4096;

    localparam int LW_BITS = 13;
    localparam logic [LW_BITS-1:0] LW_RESET = 13'd640;

    localparam int PIX_BITS   = 8;
    localparam int SUM_BITS   = 9;
    localparam int ENTRY_BITS = 3 * SUM_BITS;
    localparam int Q_SHIFT    = 15;
    localparam int Y_ACC_BITS = 23;
    localparam int C_ACC_BITS = 26;

    // apb register map
    localparam int APB_ADDR_BITS = 2;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_LINE_WIDTH = 2'd0;

    // luma weights, q15
    localparam logic [14:0] C_Y_R = 15'd9798;
    localparam logic [14:0] C_Y_G = 15'd19235;
    localparam logic [14:0] C_Y_B = 15'd3736;

    // chroma weights, q15
    localparam logic signed [15:0] C_U_R = -16'sd5538;
    localparam logic signed [15:0] C_U_G = -16'sd10846;
    localparam logic signed [15:0] C_U_B = 16'sd16351;
    localparam logic signed [15:0] C_V_R = 16'sd16351;
    localparam logic signed [15:0] C_V_G = -16'sd13697;
    localparam logic signed [15:0] C_V_B = -16'sd2664;
    localparam int C_OFFSET = 128;

    // first stage: accepted pixel plus its horizontal pair sums
    typedef struct packed {
        logic                valid;
        logic                chroma;
        logic [PIX_BITS-1:0] red;
        logic [PIX_BITS-1:0] green;
        logic [PIX_BITS-1:0] blue;
        logic [SUM_BITS-1:0] sum_r;
        logic [SUM_BITS-1:0] sum_g;
        logic [SUM_BITS-1:0] sum_b;
    } t_stage;

endpackage

### sv/ryd_if.sv
`timescale 1ns / 1ps
// pixel and result stream interfaces
interface ryd_pix_if;
    logic                         valid;
    logic                         ready;
    logic [ryd_pkg::PIX_BITS-1:0] blue;
    logic [ryd_pkg::PIX_BITS-1:0] green;
    logic [ryd_pkg::PIX_BITS-1:0] red;
    logic                         frame_start;

    modport source (output valid, output blue, output green, output red,
                    output frame_start, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input frame_start, output ready);
endinterface

interface ryd_res_if;
    logic                         valid;
    logic                         ready;
    logic [ryd_pkg::PIX_BITS-1:0] luma;
    logic                         chroma_valid;
    logic [ryd_pkg::PIX_BITS-1:0] chroma_u;
    logic [ryd_pkg::PIX_BITS-1:0] chroma_v;

    modport source (output valid, output luma, output chroma_valid,
                    output chroma_u, output chroma_v, input ready);
    modport sink   (input valid, input luma, input chroma_valid,
                    input chroma_u, input chroma_v, output ready);
endinterface

### sv/rgb_to_yuv420_downsampler.sv
`timescale 1ns / 1ps
// rgb to yuv 4:2:0 downsampler: raster rgb in, luma per pixel, chroma per 2x2 block
//
// i_pix carries one rgb pixel per transfer in raster order; frame_start on a
// pixel makes it column 0 of an even row. o_res gives exactly one result per
// pixel: luma always, and on the second pixel of each pair in odd rows also
// chroma_u and chroma_v with chroma_valid set. The row length comes from the
// apb register line_width (byte address 0, reset 640, rounded down to even,
// kept within 2..MAX_WIDTH); write it only while the block is idle.
// Even rows store horizontal pair sums in a line store ram of MAX_WIDTH/2
// entries; odd rows read them back one row later, so a read never meets a
// write to the same entry in flight.
// One pixel is taken every cycle unless o_res stalls. A result reaches o_res
// from its input transfer through the line store read at the transfer edge,
// then luma/average, chroma products and the output register.
// A stall on o_res freezes the whole pipeline and drops
// i_pix.ready in the same cycle; the output register holds its result.
// Synchronous reset clears position, held pixel and the pipeline; the line
// store is not cleared and needs no init pass.
module rgb_to_yuv420_downsampler #(
    parameter int MAX_WIDTH = ryd_pkg::MAX_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ryd_pix_if.sink                           i_pix,
    ryd_res_if.source                         o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ryd_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ryd_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ryd_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ryd_pkg::LW_BITS-1:0]    r_line_width;
    logic                           ram_we, ram_re, adv;
    logic [AW-1:0]                  ram_addr;
    logic [ryd_pkg::ENTRY_BITS-1:0] ram_wdata, ram_rdata;
    ryd_pkg::t_stage                s1;

    assign pready = 1'b1;
    assign prdata = (paddr == ryd_pkg::ADDR_LINE_WIDTH) ?
                    ryd_pkg::APB_DATA_BITS'(r_line_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= ryd_pkg::LW_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr == ryd_pkg::ADDR_LINE_WIDTH) begin
            r_line_width <= pwdata[ryd_pkg::LW_BITS-1:0];
        end
    end

    ryd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_adv        (adv),
        .i_line_width (r_line_width),
        .o_ram_we     (ram_we),
        .o_ram_re     (ram_re),
        .o_ram_addr   (ram_addr),
        .o_ram_wdata  (ram_wdata),
        .o_s1         (s1)
    );

    ryd_ram #(
        .WIDTH (ryd_pkg::ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    ryd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .i_rdata (ram_rdata),
        .o_adv   (adv),
        .o_res   (o_res)
    );

endmodule

### sv/ryd_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram with registered read
module ryd_ram #(
    parameter int WIDTH = ryd_pkg::ENTRY_BITS,
    parameter int DEPTH = ryd_pkg::MAX_WIDTH / 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ryd_ctrl.sv
`timescale 1ns / 1ps
// raster position tracking, pair summing and line store access
module ryd_ctrl #(
    parameter int MAX_WIDTH = ryd_pkg::MAX_WIDTH,
    localparam int AW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ryd_pix_if.sink                        i_pix,
    input  logic                           i_adv,
    input  logic [ryd_pkg::LW_BITS-1:0]    i_line_width,
    output logic                           o_ram_we,
    output logic                           o_ram_re,
    output logic [AW-1:0]                  o_ram_addr,
    output logic [ryd_pkg::ENTRY_BITS-1:0] o_ram_wdata,
    output ryd_pkg::t_stage                o_s1
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = ($clog2(MAX_WIDTH + 1) > ryd_pkg::LW_BITS) ?
                        $clog2(MAX_WIDTH + 1) : ryd_pkg::LW_BITS;
    localparam logic [XW-1:0] CAP = XW'(MAX_WIDTH - (MAX_WIDTH % 2));

    logic [CW-1:0]   r_col, n_col;
    logic            r_odd, n_odd;
    logic [23:0]     r_held, n_held;
    logic            r_s1_v;
    ryd_pkg::t_stage r_s1, n_s1;

    logic [XW-1:0] lw_even, width, col_next;
    logic [CW-1:0] col_eff;
    logic          odd_eff, wrap_pre, accept;
    logic [CW:0]   slot;

    assign accept      = i_pix.valid & i_adv;
    assign i_pix.ready = i_adv;

    always_comb begin
        lw_even = XW'({i_line_width[ryd_pkg::LW_BITS-1:1], 1'b0});
        width   = (lw_even > CAP) ? CAP : lw_even;
        if (width < XW'(2)) begin
            width = XW'(2);
        end

        // a shrunken width can leave the column past the row end
        wrap_pre = XW'(r_col) >= width;
        if (i_pix.frame_start) begin
            col_eff = '0;
            odd_eff = 1'b0;
        end else if (wrap_pre) begin
            col_eff = '0;
            odd_eff = ~r_odd;
        end else begin
            col_eff = r_col;
            odd_eff = r_odd;
        end

        col_next = XW'(col_eff) + XW'(1);
        if (col_next >= width) begin
            n_col = '0;
            n_odd = ~odd_eff;
        end else begin
            n_col = col_next[CW-1:0];
            n_odd = odd_eff;
        end

        n_held = col_eff[0] ? r_held : {i_pix.red, i_pix.green, i_pix.blue};

        n_s1.valid  = 1'b1;
        n_s1.chroma = col_eff[0] & odd_eff;
        n_s1.red    = i_pix.red;
        n_s1.green  = i_pix.green;
        n_s1.blue   = i_pix.blue;
        n_s1.sum_r  = ryd_pkg::SUM_BITS'(i_pix.red)   + ryd_pkg::SUM_BITS'(r_held[23:16]);
        n_s1.sum_g  = ryd_pkg::SUM_BITS'(i_pix.green) + ryd_pkg::SUM_BITS'(r_held[15:8]);
        n_s1.sum_b  = ryd_pkg::SUM_BITS'(i_pix.blue)  + ryd_pkg::SUM_BITS'(r_held[7:0]);

        // writes happen on even rows and reads on odd rows, never in the same cycle
        slot        = (CW + 1)'(col_eff) >> 1;
        o_ram_addr  = slot[AW-1:0];
        o_ram_wdata = {n_s1.sum_r, n_s1.sum_g, n_s1.sum_b};
        o_ram_we    = accept & col_eff[0] & ~odd_eff;
        o_ram_re    = accept & col_eff[0] & odd_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_odd  <= 1'b0;
            r_held <= '0;
            r_s1_v <= 1'b0;
        end else if (i_adv) begin
            r_s1_v <= i_pix.valid;
            if (accept) begin
                r_col  <= n_col;
                r_odd  <= n_odd;
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    always_comb begin
        o_s1       = r_s1;
        o_s1.valid = r_s1_v;
    end

endmodule

### sv/ryd_conv.sv
`timescale 1ns / 1ps
// color conversion pipeline and output register
module ryd_conv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ryd_pkg::t_stage                i_s1,
    input  logic [ryd_pkg::ENTRY_BITS-1:0] i_rdata,
    output logic                           o_adv,
    ryd_res_if.source                      o_res
);

    localparam int SB = ryd_pkg::SUM_BITS;
    localparam int CA = ryd_pkg::C_ACC_BITS;
    localparam int YA = ryd_pkg::Y_ACC_BITS;

    function automatic logic [7:0] clamp8(input logic signed [CA-1:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > CA'(255)) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // stage 2
    logic          r_s2_v, r_s2_c;
    logic [YA-1:0] r_y_acc, n_y_acc;
    logic [SB-1:0] r_avg_r, r_avg_g, r_avg_b;
    logic [SB-1:0] n_avg_r, n_avg_g, n_avg_b;
    // stage 3
    logic                 r_s3_v, r_s3_c;
    logic [7:0]           r_y;
    logic signed [CA-1:0] r_u_acc, r_v_acc, n_u_acc, n_v_acc;
    logic signed [CA-1:0] s_r, s_g, s_b;
    // output
    logic                 r_out_v, r_cv;
    logic [7:0]           r_luma, r_u, r_v;
    logic signed [CA-1:0] u_off, v_off;

    assign o_adv = ~r_out_v | o_res.ready;

    always_comb begin
        n_y_acc = YA'(ryd_pkg::C_Y_R) * YA'(i_s1.red)
                + YA'(ryd_pkg::C_Y_G) * YA'(i_s1.green)
                + YA'(ryd_pkg::C_Y_B) * YA'(i_s1.blue);
        // rounded 2x2 average from stored and current pair sums
        n_avg_r = SB'((11'(i_s1.sum_r) + 11'(i_rdata[3*SB-1:2*SB]) + 11'd2) >> 2);
        n_avg_g = SB'((11'(i_s1.sum_g) + 11'(i_rdata[2*SB-1:SB]) + 11'd2) >> 2);
        n_avg_b = SB'((11'(i_s1.sum_b) + 11'(i_rdata[SB-1:0]) + 11'd2) >> 2);

        s_r = $signed({{(CA - SB){1'b0}}, r_avg_r});
        s_g = $signed({{(CA - SB){1'b0}}, r_avg_g});
        s_b = $signed({{(CA - SB){1'b0}}, r_avg_b});
        n_u_acc = s_r * ryd_pkg::C_U_R + s_g * ryd_pkg::C_U_G + s_b * ryd_pkg::C_U_B;
        n_v_acc = s_r * ryd_pkg::C_V_R + s_g * ryd_pkg::C_V_G + s_b * ryd_pkg::C_V_B;

        // arithmetic shift floors toward minus infinity
        u_off = (r_u_acc >>> ryd_pkg::Q_SHIFT) + CA'(ryd_pkg::C_OFFSET);
        v_off = (r_v_acc >>> ryd_pkg::Q_SHIFT) + CA'(ryd_pkg::C_OFFSET);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (o_adv) begin
            r_s2_v  <= i_s1.valid;
            r_s3_v  <= r_s2_v;
            r_out_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s2_c  <= i_s1.chroma;
            r_y_acc <= n_y_acc;
            r_avg_r <= n_avg_r;
            r_avg_g <= n_avg_g;
            r_avg_b <= n_avg_b;

            r_s3_c  <= r_s2_c;
            r_y     <= clamp8(CA'(r_y_acc >> ryd_pkg::Q_SHIFT));
            r_u_acc <= n_u_acc;
            r_v_acc <= n_v_acc;

            r_luma  <= r_y;
            r_cv    <= r_s3_c;
            r_u     <= r_s3_c ? clamp8(u_off) : 8'd0;
            r_v     <= r_s3_c ? clamp8(v_off) : 8'd0;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.luma         = r_luma;
    assign o_res.chroma_valid = r_cv;
    assign o_res.chroma_u     = r_u;
    assign o_res.chroma_v     = r_v;

endmodule
